// ===== hdl/fragment_reassembly_tracker_assert.svh =====
// Assertion macros for the fragment reassembly tracker.
// Needs clk_i and rst_ni in the module that uses them; no other dependencies.
`ifndef FRAGMENT_REASSEMBLY_TRACKER_ASSERT_SVH
`define FRAGMENT_REASSEMBLY_TRACKER_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset
`define FRT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset
`define FRT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/frt_pkg.sv =====
// Shared types and constants for the fragment reassembly tracker.
// No dependencies; imported by the controller, datapath and top level.
`default_nettype none

package frt_pkg;

  localparam int MAX_FRAGMENTS = 64;
  localparam int HEADER_BYTES  = 6;
  localparam int FRAME_LEN_W   = 11;
  localparam int BYTE_SUM_W    = 17;
  localparam int RX_TOTAL_W    = 7;
  localparam int FIELD_W       = 16;

  localparam int IDX_W = (MAX_FRAGMENTS > 1) ? $clog2(MAX_FRAGMENTS) : 1;
  localparam int CNT_W = $clog2(MAX_FRAGMENTS + 1);

  localparam logic [BYTE_SUM_W-1:0] BYTE_SUM_MAX = '1;

  // Reject codes
  localparam logic [2:0] REJ_NONE  = 3'd0;
  localparam logic [2:0] REJ_SHORT = 3'd1;
  localparam logic [2:0] REJ_ZERO  = 3'd2;
  localparam logic [2:0] REJ_RANGE = 3'd3;
  localparam logic [2:0] REJ_DUP   = 3'd4;
  localparam logic [2:0] REJ_OVER  = 3'd5;

  typedef struct packed {
    logic [FIELD_W-1:0]     frag_msg_id;
    logic [FIELD_W-1:0]     frag_index;
    logic [FIELD_W-1:0]     frag_total;
    logic [FRAME_LEN_W-1:0] frame_length;
  } frt_in_t;

  typedef struct packed {
    logic                  accepted;
    logic [2:0]            reject_code;
    logic                  restarted;
    logic                  message_complete;
    logic [RX_TOTAL_W-1:0] received_total;
    logic [BYTE_SUM_W-1:0] payload_bytes;
  } frt_out_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;  // capture the fragment header
    logic eval;  // evaluate and commit tracking state
  } frt_cmd_t;

endpackage

`default_nettype wire

// ===== hdl/frt_ctrl.sv =====
// Sequencing controller for the fragment reassembly tracker.
// Depends on frt_pkg and fragment_reassembly_tracker_assert.svh.
`default_nettype none
`include "fragment_reassembly_tracker_assert.svh"

module frt_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start,
  output logic                 busy,
  output logic                 res_strobe_o,
  output frt_pkg::frt_cmd_t    cmd_o
);
  import frt_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EVAL = 1'b1;

  logic state_q, state_d;
  logic strobe_q, strobe_d;

  always_comb begin
    cmd_o.load = start && (state_q == ST_IDLE);
    cmd_o.eval = (state_q == ST_EVAL);
    strobe_d   = (state_q == ST_EVAL);
    unique case (state_q)
      ST_IDLE: state_d = cmd_o.load ? ST_EVAL : ST_IDLE;
      ST_EVAL: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      strobe_q <= strobe_d;
    end
  end

  assign busy         = (state_q == ST_EVAL);
  assign res_strobe_o = strobe_q;

  `FRT_ASSERT_NEXT(a_load_then_eval, cmd_o.load, cmd_o.eval, "transfer taken but no evaluate cycle")
  `FRT_ASSERT_NEXT(a_eval_then_strobe, cmd_o.eval, res_strobe_o, "evaluate cycle without result strobe")
  `FRT_ASSERT_NOW(a_strobe_idle, res_strobe_o, !busy, "result strobe while still busy")

endmodule

`default_nettype wire

// ===== hdl/frt_datapath.sv =====
// Tracking state, header checks and result register for the reassembly tracker.
// Depends on frt_pkg and fragment_reassembly_tracker_assert.svh.
`default_nettype none
`include "fragment_reassembly_tracker_assert.svh"

module frt_datapath (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  frt_pkg::frt_cmd_t      cmd_i,
  input  frt_pkg::frt_in_t       frag_i,
  output frt_pkg::frt_out_t      res_o
);
  import frt_pkg::*;

  frt_in_t  in_q;
  frt_out_t res_q, res_d;

  logic                     active_q, active_d;
  logic [FIELD_W-1:0]       id_q, id_d;
  logic [CNT_W-1:0]         count_q, count_d;
  logic [CNT_W-1:0]         arrived_q, arrived_d;
  logic [MAX_FRAGMENTS-1:0] map_q, map_d;
  logic [BYTE_SUM_W-1:0]    sum_q, sum_d;

  logic [2:0]               code_pre;
  logic                     hdr_ok;
  logic                     restart;
  logic                     dup;
  logic [IDX_W-1:0]         idx_lo;
  logic [MAX_FRAGMENTS-1:0] map_base;
  logic [CNT_W-1:0]         cnt_base;
  logic [BYTE_SUM_W-1:0]    sum_base;
  logic [FRAME_LEN_W-1:0]   pay_len;
  logic [BYTE_SUM_W:0]      sum_wide;
  logic [CNT_W+RX_TOTAL_W-1:0] arrived_ext;

  always_comb begin
    priority if (in_q.frame_length < FRAME_LEN_W'(HEADER_BYTES)) begin
      code_pre = REJ_SHORT;
    end else if (in_q.frag_total == '0) begin
      code_pre = REJ_ZERO;
    end else if (in_q.frag_index >= in_q.frag_total) begin
      code_pre = REJ_RANGE;
    end else if (in_q.frag_total > FIELD_W'(MAX_FRAGMENTS)) begin
      code_pre = REJ_OVER;
    end else begin
      code_pre = REJ_NONE;
    end

    hdr_ok  = (code_pre == REJ_NONE);
    restart = hdr_ok && (!active_q || (in_q.frag_msg_id != id_q) ||
              (in_q.frag_total != {{(FIELD_W-CNT_W){1'b0}}, count_q}));

    // Index and count fit the narrow widths once the header checks pass
    idx_lo   = in_q.frag_index[IDX_W-1:0];
    map_base = restart ? '0 : map_q;
    cnt_base = restart ? '0 : arrived_q;
    sum_base = restart ? '0 : sum_q;
    dup      = map_base[idx_lo];
    pay_len  = in_q.frame_length - FRAME_LEN_W'(HEADER_BYTES);
    sum_wide = {1'b0, sum_base} + {{(BYTE_SUM_W+1-FRAME_LEN_W){1'b0}}, pay_len};

    active_d = active_q;
    id_d     = id_q;
    count_d  = count_q;
    arrived_d = arrived_q;
    map_d    = map_q;
    sum_d    = sum_q;
    res_d.accepted    = 1'b0;
    res_d.reject_code = code_pre;
    res_d.restarted   = restart;

    if (hdr_ok) begin
      active_d  = 1'b1;
      id_d      = in_q.frag_msg_id;
      count_d   = in_q.frag_total[CNT_W-1:0];
      arrived_d = cnt_base;
      map_d     = map_base;
      sum_d     = sum_base;
      if (dup) begin
        res_d.reject_code = REJ_DUP;
      end else begin
        map_d[idx_lo]  = 1'b1;
        arrived_d      = cnt_base + CNT_W'(1);
        // Saturate the byte total at all ones
        sum_d          = sum_wide[BYTE_SUM_W] ? BYTE_SUM_MAX : sum_wide[BYTE_SUM_W-1:0];
        res_d.accepted = 1'b1;
      end
    end

    arrived_ext = {{RX_TOTAL_W{1'b0}}, arrived_d};
    res_d.message_complete = active_d && (count_d != '0) && (arrived_d == count_d);
    res_d.received_total   = arrived_ext[RX_TOTAL_W-1:0];
    res_d.payload_bytes    = sum_d;
  end

  // Payload registers: no reset needed
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      in_q <= frag_i;
    end
    if (cmd_i.eval) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q  <= 1'b0;
      id_q      <= '0;
      count_q   <= '0;
      arrived_q <= '0;
      map_q     <= '0;
      sum_q     <= '0;
    end else if (cmd_i.eval) begin
      active_q  <= active_d;
      id_q      <= id_d;
      count_q   <= count_d;
      arrived_q <= arrived_d;
      map_q     <= map_d;
      sum_q     <= sum_d;
    end
  end

  assign res_o = res_q;

  `FRT_ASSERT_NOW(a_idle_empty, !active_q, (arrived_q == '0) && (map_q == '0), "arrivals recorded with no message")
  `FRT_ASSERT_NOW(a_count_bound, active_q, arrived_q <= count_q, "arrival count above declared count")
  `FRT_ASSERT_NOW(a_map_count, 1'b1, $countones(map_q) == int'(arrived_q), "arrival map disagrees with count")

endmodule

`default_nettype wire

// ===== hdl/fragment_reassembly_tracker.sv =====
// Top level of the fragment reassembly tracker: controller plus datapath.
// Depends on frt_pkg, frt_ctrl and frt_datapath.
//
// One fragment header is taken per transfer (start high while busy is low) and
// one result follows for every transfer, on res_o with res_strobe_o high for
// exactly one cycle; the receiver cannot stall it. The header is captured at
// the transfer edge, the next cycle runs the checks, tests and sets the
// arrival bit, and updates the count and byte total, and the result register
// loads at the end of that cycle. The strobe comes from a register that loads
// alongside it. busy is high during the evaluate cycle only, so a new fragment
// cannot be taken until that cycle is over; it can be taken at the edge that
// ends the previous result strobe. Reset clears all tracking state at once.
`default_nettype none

module fragment_reassembly_tracker (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start,
  output logic                busy,
  input  frt_pkg::frt_in_t    frag_i,
  output logic                res_strobe_o,
  output frt_pkg::frt_out_t   res_o
);
  import frt_pkg::*;

  frt_cmd_t cmd;

  frt_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .res_strobe_o (res_strobe_o),
    .cmd_o        (cmd)
  );

  frt_datapath u_datapath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .frag_i (frag_i),
    .res_o  (res_o)
  );

endmodule

`default_nettype wire
